[design/vrt_pkg.sv]
// Package for the voxel ray traversal block: types, constants and field packing.
// No dependencies; used by every module of the block.
`default_nettype none
package vrt_pkg;
  localparam int MaxVoxels = 64;
  localparam int CntW = 7;
  localparam logic [31:0] TOne = 32'h0100_0000;
  localparam logic [31:0] TSat = 32'hFFFF_FFFF;
  localparam logic [1:0] SignNone = 2'd0;
  localparam logic [1:0] SignUp = 2'd1;
  localparam logic [1:0] SignDown = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_EMIT, ST_WAIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture segment, start setup
    logic div_start; // start one division
    logic advance;   // step the chosen axis
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;  // all divisions finished
    logic div_busy;  // one division in flight
    logic finished;  // travelled beyond t = 1 after this step
  } dp_sts_t;
endpackage
`default_nettype wire

[design/voxel_ray_traversal.sv]
// Voxel ray traversal top level: 3D DDA over a Q16.8 segment.
// Setup runs six divisions on one shared divider after the segment is taken; an axis
// with no extent skips its two divisions. Then one voxel item per cycle while
// out_tready is high, up to 64; a new segment is taken in the cycle after the last
// voxel item is delivered. Reset (rst_n low, synchronous) returns to idle.
`default_nettype none
module voxel_ray_traversal
  import vrt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z (24 bits each)
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // voxel_x, voxel_y, voxel_z (16 bits each)
  output logic [47:0]       out_tdata,
  output logic              out_tlast,
  // truncated
  output logic              out_tuser
);
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [15:0] vx, vy, vz;
  logic fire;

  assign fire = in_tvalid && in_tready;

  vrt_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .start_x(in_tdata[23:0]), .start_y(in_tdata[47:24]), .start_z(in_tdata[71:48]),
    .end_x(in_tdata[95:72]), .end_y(in_tdata[119:96]), .end_z(in_tdata[143:120]),
    .sts(sts), .vx(vx), .vy(vy), .vz(vz)
  );

  vrt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(fire), .out_ready(out_tready),
    .sts(sts), .div_busy(sts.div_busy), .cmd(cmd), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_last(out_tlast), .out_trunc(out_tuser)
  );

  assign out_tdata = {vz, vy, vx};

  // no input taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input accepted during emission");
  // truncated only with last
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast) else $error("truncated without last");
endmodule
`default_nettype wire

[design/vrt_div.sv]
// Restoring divider, one quotient bit per cycle, 57-bit dividend by 25-bit divisor.
// Depends on vrt_pkg.
`default_nettype none
module vrt_div
  import vrt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [56:0] dividend,
  input  wire logic [24:0] divisor,
  output logic             done,
  output logic [31:0]      quot
);
  logic [56:0] q_r, q_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [24:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [25:0] trial;
  logic [25:0] sh;

  // shift one bit in and try subtracting
  always_comb begin
    sh = {rem_r[24:0], q_r[56]};
    trial = sh - {1'b0, d_r};
    q_nxt = {q_r[55:0], 1'b0};
    rem_nxt = sh;
    if (sh >= {1'b0, d_r}) begin
      rem_nxt = trial;
      q_nxt[0] = 1'b1;
    end
    cnt_nxt = cnt_r + 6'd1;
    run_nxt = run_r && (cnt_r != 6'd56);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      rem_r <= '0;
      d_r <= divisor;
    end else if (run_r) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = run_r && (cnt_r == 6'd56);
  // saturate to 32 bits
  assign quot = (|q_nxt[56:32]) ? TSat : q_nxt[31:0];
endmodule
`default_nettype wire

[design/vrt_datapath.sv]
// Datapath: per-axis setup, shared divider, crossing compare and voxel stepping.
// Depends on vrt_pkg and vrt_div.
`default_nettype none
module vrt_datapath
  import vrt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dp_cmd_t            cmd,
  input  wire logic signed [23:0] start_x,
  input  wire logic signed [23:0] start_y,
  input  wire logic signed [23:0] start_z,
  input  wire logic signed [23:0] end_x,
  input  wire logic signed [23:0] end_y,
  input  wire logic signed [23:0] end_z,
  output dp_sts_t                 sts,
  output logic [15:0]             vx,
  output logic [15:0]             vy,
  output logic [15:0]             vz
);
  logic [15:0] vox_r [3];
  logic [31:0] cross_r [3];
  logic [31:0] inc_r [3];
  logic [1:0]  sign_r [3];
  logic [24:0] dist_r [3];
  logic [8:0]  f_r [3];
  logic [2:0]  job_r, job_nxt;   // 0..5: inc x,y,z then cross x,y,z
  logic        div_run_r;
  logic signed [24:0] diff [3];
  logic signed [23:0] s [3];
  logic signed [23:0] e [3];
  logic [56:0] dvd;
  logic [24:0] dvs;
  logic [1:0]  jax;
  logic        dv_done;
  logic [31:0] dv_q;
  logic [1:0]  ax;
  logic [32:0] sum;

  assign s[0] = start_x; assign s[1] = start_y; assign s[2] = start_z;
  assign e[0] = end_x;   assign e[1] = end_y;   assign e[2] = end_z;

  always_comb begin
    for (int k = 0; k < 3; k++) diff[k] = 25'(e[k]) - 25'(s[k]);
  end

  // select the current division job
  always_comb begin
    jax = (job_r >= 3'd3) ? 2'(job_r - 3'd3) : job_r[1:0];
    dvs = dist_r[jax];
    dvd = (job_r < 3'd3) ? {24'd0, 1'b1, 32'd0} : {24'd0, f_r[jax], 24'd0};
  end

  vrt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start && (dvs != '0)),
    .dividend(dvd), .divisor(dvs), .done(dv_done), .quot(dv_q)
  );

  // pick the axis with the smallest crossing; y wins over x, z over both
  always_comb begin
    if (cross_r[0] < cross_r[1]) ax = (cross_r[0] < cross_r[2]) ? 2'd0 : 2'd2;
    else ax = (cross_r[1] < cross_r[2]) ? 2'd1 : 2'd2;
    sum = {1'b0, cross_r[ax]} + {1'b0, inc_r[ax]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= '0;
      div_run_r <= 1'b0;
    end else if (cmd.load) begin
      job_r <= '0;
      div_run_r <= 1'b0;
    end else if (cmd.div_start) begin
      // skip zero-extent axes at once
      div_run_r <= (dvs != '0);
      if (dvs == '0) job_r <= job_r + 3'd1;
    end else if (div_run_r && dv_done) begin
      div_run_r <= 1'b0;
      job_r <= job_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        vox_r[k] <= s[k][23:8];
        if (diff[k] == '0) begin
          sign_r[k] <= SignNone;
          dist_r[k] <= '0;
          f_r[k] <= '0;
        end else if (!diff[k][24]) begin
          sign_r[k] <= SignUp;
          dist_r[k] <= diff[k];
          f_r[k] <= 9'd256 - {1'b0, s[k][7:0]};
        end else begin
          sign_r[k] <= SignDown;
          dist_r[k] <= 25'd0 - diff[k];
          f_r[k] <= {1'b0, s[k][7:0]};
        end
        cross_r[k] <= TSat;
        inc_r[k] <= TSat;
      end
    end else if (div_run_r && dv_done) begin
      if (job_r < 3'd3) inc_r[jax] <= dv_q;
      else cross_r[jax] <= dv_q;
    end else if (cmd.advance) begin
      if (sign_r[ax] == SignUp) vox_r[ax] <= vox_r[ax] + 16'd1;
      else if (sign_r[ax] == SignDown) vox_r[ax] <= vox_r[ax] - 16'd1;
      cross_r[ax] <= sum[32] ? TSat : sum[31:0];
    end
  end

  assign sts.div_done = (job_r == 3'd6);
  assign sts.div_busy = div_run_r;
  assign sts.finished = (cross_r[ax] > TOne);
  assign vx = vox_r[0];
  assign vy = vox_r[1];
  assign vz = vox_r[2];
endmodule
`default_nettype wire

[design/vrt_ctrl.sv]
// Controller: sequences setup divisions and the voxel emission loop.
// Depends on vrt_pkg.
`default_nettype none
module vrt_ctrl
  import vrt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_fire,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  input  wire logic    div_busy,
  output dp_cmd_t      cmd,
  output logic         in_ready,
  output logic         out_valid,
  output logic         out_last,
  output logic         out_trunc
);
  state_t st_r, st_nxt;
  logic [CntW-1:0] cnt_r;
  logic is_last, cut;

  assign cut = (cnt_r == CntW'(MaxVoxels - 1));
  assign is_last = sts.finished || cut;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (in_fire) st_nxt = ST_DIV;
      ST_DIV:  if (sts.div_done) st_nxt = ST_EMIT;
               else if (!div_busy) st_nxt = ST_WAIT;
      ST_WAIT: if (sts.div_done) st_nxt = ST_EMIT;
               else if (!div_busy) st_nxt = ST_WAIT;
      ST_EMIT: if (out_ready && is_last) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      ST_DIV, ST_WAIT: cmd.div_start = !sts.div_done && !div_busy;
      ST_EMIT: begin
        out_valid = 1'b1;
        cmd.advance = out_ready;
      end
      default: ;
    endcase
    out_last = is_last;
    out_trunc = cut && !sts.finished;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_IDLE) cnt_r <= '0;
      else if (cmd.advance) cnt_r <= cnt_r + CntW'(1);
    end
  end
endmodule
`default_nettype wire
